[hdl/utf8_cyrillic_latin_lowercase_unit_assert.svh]
// Assertion macros for the lowercase unit.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef UTF8_CYRILLIC_LATIN_LOWERCASE_UNIT_ASSERT_SVH
`define UTF8_CYRILLIC_LATIN_LOWERCASE_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge out of reset
`define U8CYR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A condition that, when seen, forces another one on the next edge
`define U8CYR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/u8cyr_pkg.sv]
// Shared types and constants for the UTF-8 Cyrillic/Latin lowercase unit.
// No dependencies.
`timescale 1ns / 1ps

package u8cyr_pkg;

    // Lead bytes of the two-byte sequences that are handled
    localparam logic [7:0] LEAD_A = 8'hD0;
    localparam logic [7:0] LEAD_B = 8'hD1;
    localparam logic [7:0] LEAD_C = 8'hD2;

    localparam logic [7:0] ASCII_UP_LO = 8'h41;
    localparam logic [7:0] ASCII_UP_HI = 8'h5A;
    localparam logic [7:0] CASE_BIT    = 8'h20;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CYR_IO_UP   = 8'h81;
    localparam logic [7:0] CYR_IO_LO   = 8'hB5;
    localparam logic [7:0] CYR_IO_D1   = 8'h91;
    localparam logic [7:0] CYR_R1_LO   = 8'h90;
    localparam logic [7:0] CYR_R1_HI   = 8'h9F;
    localparam logic [7:0] CYR_R2_HI   = 8'hAF;
    localparam logic [7:0] SHIFT_16    = 8'h10;
    localparam logic [7:0] EXT_LO      = 8'h8A;
    localparam logic [7:0] EXT_HI      = 8'hBF;

    // Queue between the classifier and the serialiser
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // One classified transfer: one or two output bytes
    typedef struct packed {
        logic       two;
        logic [7:0] first;
        logic [7:0] second;
        logic       last;
    } t_entry;

    // Queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_head;

endpackage

[hdl/utf8_cyrillic_latin_lowercase_unit.sv]
// With the queue empty, an accepted transfer passes through the queue storage and then the output register to o_item.
// Throughput: one input byte per cycle while the queue is not full; one output byte per
// cycle while the consumer pops, set by the single output register, so a converted pair leaves one byte at a time.
// A held lead byte produces no output until its follower arrives.
// Reset (synchronous, active low) clears the held lead, the queue and the output.
// Depends on u8cyr_pkg, u8cyr_front, u8cyr_queue, u8cyr_back and the assertion macro header.
`timescale 1ns / 1ps
`include "utf8_cyrillic_latin_lowercase_unit_assert.svh"

module utf8_cyrillic_latin_lowercase_unit
    import u8cyr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    logic    w_accept;
    logic    w_q_push;
    t_entry  w_q_entry;
    logic    w_q_pop;
    logic    w_q_full;
    t_q_head w_q_head;

    assign w_accept = push && !full;
    assign full     = w_q_full;

    // Classifier
    u8cyr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .o_push   (w_q_push),
        .o_entry  (w_q_entry)
    );

    // Decoupling queue
    u8cyr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_entry (w_q_entry),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_head  (w_q_head)
    );

    // Serialiser and output register
    u8cyr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_q_head),
        .o_q_pop (w_q_pop),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (o_item)
    );

    // Queue is never written when full nor read when empty
    `U8CYR_ASSERT_ALWAYS(a_no_q_overflow, !(w_q_push && w_q_full), "queue overflow")
    `U8CYR_ASSERT_ALWAYS(a_no_q_underflow, !(w_q_pop && !w_q_head.valid), "queue underflow")
    // A retired queue entry always leaves its last byte in the output register
    `U8CYR_ASSERT_NEXT(a_pop_loads_out, w_q_pop, !empty, "entry retired without output")

endmodule

[hdl/u8cyr_front.sv]
// Front end: holds a pending lead byte and classifies each input transfer
// into a queue entry of zero, one or two bytes. Depends on u8cyr_pkg.
`timescale 1ns / 1ps

module u8cyr_front
    import u8cyr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_push,
    output t_entry   o_entry
);

    logic       r_pending, n_pending;
    logic [7:0] r_held, n_held;

    logic [7:0] w_b;
    logic       w_last;
    logic       w_lead;
    logic [7:0] w_single;
    logic [7:0] w_a_lead;
    logic [7:0] w_a_sec;
    logic [7:0] w_c_sec;

    assign w_b    = i_item.in_byte;
    assign w_last = i_item.is_last;
    assign w_lead = (w_b == LEAD_A) || (w_b == LEAD_B) || (w_b == LEAD_C);

    // ASCII capitals fold to lower case, everything else passes
    assign w_single = ((w_b >= ASCII_UP_LO) && (w_b <= ASCII_UP_HI)) ? (w_b | CASE_BIT) : w_b;

    // Second byte after D0
    always_comb begin
        w_a_lead = LEAD_A;
        w_a_sec  = w_b;
        if (w_b >= CYR_R1_LO) begin
            if (w_b <= CYR_R1_HI) begin
                w_a_sec = w_b + CASE_BIT;
            end else if (w_b <= CYR_R2_HI) begin
                w_a_lead = LEAD_B;
                w_a_sec  = w_b - CASE_BIT;
            end
        end else if (w_b == CYR_IO_UP) begin
            w_a_sec = CYR_IO_LO;
        end else if (w_b >= CONT_LO) begin
            w_a_lead = LEAD_B;
            w_a_sec  = w_b + SHIFT_16;
        end
    end

    // Second byte after D2
    assign w_c_sec = ((w_b >= EXT_LO) && (w_b <= EXT_HI)) ? (w_b | 8'h01) : w_b;

    // Classification and next held state
    always_comb begin
        n_pending = r_pending;
        n_held    = r_held;
        o_push    = 1'b0;
        o_entry   = '0;
        if (i_accept) begin
            if (!r_pending) begin
                if (w_lead && !w_last) begin
                    n_pending = 1'b1;
                    n_held    = w_b;
                end else begin
                    o_push        = 1'b1;
                    o_entry.first = w_single;
                    o_entry.last  = w_last;
                end
            end else begin
                n_pending = 1'b0;
                n_held    = '0;
                o_push    = 1'b1;
                case (r_held)
                    LEAD_A: begin
                        o_entry = '{two: 1'b1, first: w_a_lead, second: w_a_sec,
                                    last: w_last};
                    end
                    LEAD_C: begin
                        o_entry = '{two: 1'b1, first: LEAD_C, second: w_c_sec,
                                    last: w_last};
                    end
                    default: begin
                        // held D1
                        if (w_b == CYR_IO_D1) begin
                            o_entry = '{two: 1'b1, first: LEAD_A, second: CYR_IO_LO,
                                        last: w_last};
                        end else if (w_lead && !w_last) begin
                            // flush D1, the new lead takes its place
                            o_entry   = '{two: 1'b0, first: LEAD_B, second: 8'h00,
                                          last: 1'b0};
                            n_pending = 1'b1;
                            n_held    = w_b;
                        end else begin
                            o_entry = '{two: 1'b1, first: LEAD_B, second: w_single,
                                        last: w_last};
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_held    <= '0;
        end else begin
            r_pending <= n_pending;
            r_held    <= n_held;
        end
    end

endmodule

[hdl/u8cyr_queue.sv]
// Small register queue of classified entries between front and back end.
// Depends on u8cyr_pkg.
`timescale 1ns / 1ps

module u8cyr_queue
    import u8cyr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output logic    o_full,
    output t_q_head o_head
);

    localparam logic [Q_AW:0] FULL_COUNT = (Q_AW + 1)'(Q_DEPTH);

    t_entry r_mem [Q_DEPTH];

    logic [Q_AW-1:0] r_wr, n_wr;
    logic [Q_AW-1:0] r_rd, n_rd;
    logic [Q_AW:0]   r_count, n_count;

    assign o_full       = (r_count == FULL_COUNT);
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd];

    // Pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

[hdl/u8cyr_back.sv]
// Back end: splits queue entries into single bytes and holds the output
// register that the consumer pops. Depends on u8cyr_pkg.
`timescale 1ns / 1ps

module u8cyr_back
    import u8cyr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    logic      r_half, n_half;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;
    logic      w_load;

    // Output register may take a new byte when free or being drained
    assign w_load = !r_out_valid || i_pop;

    always_comb begin
        n_half      = r_half;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        if (w_load) begin
            n_out_valid = i_head.valid;
            if (i_head.valid) begin
                if (i_head.entry.two && !r_half) begin
                    n_out.out_byte = i_head.entry.first;
                    n_out.out_last = 1'b0;
                    n_half         = 1'b1;
                end else begin
                    n_out.out_byte = r_half ? i_head.entry.second : i_head.entry.first;
                    n_out.out_last = i_head.entry.last;
                    n_half         = 1'b0;
                    o_q_pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_half      <= n_half;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

endmodule
